// ===== rtl/prea_pkg.sv =====
// Shared types and constants for the packet ring event assembler.
`default_nettype none
package prea_pkg;

   // Fixed field widths
   localparam int LOOP_BITS   = 14;
   localparam int OFF_FIELD_W = 24;
   localparam int RING_W      = 16;
   localparam int LEN_W       = 20;
   localparam int PKT_LEN_W   = 16;
   localparam int CNT_W       = 8;
   localparam int IDLE_W      = 17;
   localparam int LIMIT_W     = 16;

   // Configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   localparam logic [CSR_IDX_W-1:0] CSR_PACKET_WRAP = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_EVENT_WRAP  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RING_ENTRIES = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_BYTES   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_IDLE_LIMIT  = 3'd4;

   // Register reset values
   localparam logic [OFF_FIELD_W-1:0] RST_PACKET_WRAP  = 24'd16000000;
   localparam logic [OFF_FIELD_W-1:0] RST_EVENT_WRAP   = 24'd15000000;
   localparam logic [RING_W-1:0]      RST_RING_ENTRIES = 16'd4096;
   localparam logic [LEN_W-1:0]       RST_MAX_BYTES    = 20'd100000;
   localparam logic [LIMIT_W-1:0]     RST_IDLE_LIMIT   = 16'd50000;

   // Saturation points
   localparam logic [LEN_W-1:0]  LEN_MAX  = '1;
   localparam logic [CNT_W-1:0]  CNT_MAX  = '1;
   localparam logic [IDLE_W-1:0] IDLE_MAX = '1;

   // Queue between front and back
   localparam int Q_DEPTH = 4;
   localparam int Q_PTR_W = 2;
   localparam int Q_CNT_W = 3;

   typedef struct packed {
      logic [OFF_FIELD_W-1:0] write_offset;
      logic                   entry_missing;
      logic                   entry_end;
      logic [LOOP_BITS-1:0]   entry_loop;
      logic [PKT_LEN_W-1:0]   entry_length;
      logic [LOOP_BITS-1:0]   first_loop;
   } poll_type;

   typedef struct packed {
      logic     valid;
      poll_type poll;
   } queue_head_type;

   typedef struct packed {
      logic [OFF_FIELD_W-1:0] packet_wrap_limit;
      logic [OFF_FIELD_W-1:0] event_wrap_limit;
      logic [RING_W-1:0]      ring_entries;
      logic [LEN_W-1:0]       max_event_bytes;
      logic [LIMIT_W-1:0]     idle_limit;
   } cfg_type;

   typedef struct packed {
      logic [OFF_FIELD_W-1:0] event_start;
      logic [LEN_W-1:0]       event_length;
      logic [CNT_W-1:0]       packet_count;
      logic                   end_missing;
      logic                   timed_out;
      logic                   buffer_overwrite;
      logic                   loop_overwrite;
      logic                   oversized;
      logic                   packets_missing;
   } event_type;

endpackage
`default_nettype wire

// ===== rtl/prea_front.sv =====
// Front part: configuration registers and the poll queue.
`default_nettype none
module prea_front (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire prea_pkg::poll_type              req_poll,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [prea_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [prea_pkg::CSR_DATA_W-1:0] csr_data,
   input  wire logic                            head_pop,
   output prea_pkg::queue_head_type             head,
   output prea_pkg::cfg_type                    cfg
);
   import prea_pkg::*;

   poll_type             q_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0]   cnt_ff, cnt_in;
   cfg_type              cfg_ff, cfg_in;
   logic                 push;
   logic                 pop;

   // Accept polls while the queue has room
   assign req_stall = (cnt_ff == Q_CNT_W'(Q_DEPTH));
   assign push      = req_valid && !req_stall;
   assign pop       = head_pop && (cnt_ff != '0);

   assign head.valid = (cnt_ff != '0);
   assign head.poll  = q_ff[rd_ptr_ff];

   // Advance queue pointers
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Store the accepted poll
   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= req_poll;
      end
   end

   // Decode configuration writes
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_PACKET_WRAP:  cfg_in.packet_wrap_limit = csr_data;
            CSR_EVENT_WRAP:   cfg_in.event_wrap_limit  = csr_data;
            CSR_RING_ENTRIES: cfg_in.ring_entries      = csr_data[RING_W-1:0];
            CSR_MAX_BYTES:    cfg_in.max_event_bytes   = csr_data[LEN_W-1:0];
            CSR_IDLE_LIMIT:   cfg_in.idle_limit        = csr_data[LIMIT_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.packet_wrap_limit <= RST_PACKET_WRAP;
         cfg_ff.event_wrap_limit  <= RST_EVENT_WRAP;
         cfg_ff.ring_entries      <= RST_RING_ENTRIES;
         cfg_ff.max_event_bytes   <= RST_MAX_BYTES;
         cfg_ff.idle_limit        <= RST_IDLE_LIMIT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

   // Queue fill never exceeds its depth
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= Q_CNT_W'(Q_DEPTH))
      else $error("poll queue overfilled");

   // Pointer distance matches the fill count
   a_ptr_match: assert property (@(posedge clock) disable iff (reset)
      (wr_ptr_ff - rd_ptr_ff) == cnt_ff[Q_PTR_W-1:0])
      else $error("queue pointers out of step with count");

   // A push on a full queue is refused
   a_no_overfill: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == Q_CNT_W'(Q_DEPTH)) && !pop |=> cnt_ff == Q_CNT_W'(Q_DEPTH))
      else $error("full queue changed without pop");

endmodule
`default_nettype wire

// ===== rtl/prea_back.sv =====
// Back part: ring pointer state, event accumulation and the record register.
`default_nettype none
module prea_back #(
   parameter int OFFSET_BITS = 24
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire prea_pkg::queue_head_type   head,
   output logic                            head_pop,
   input  wire prea_pkg::cfg_type          cfg,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output prea_pkg::event_type             rsp_event
);
   import prea_pkg::*;

   localparam int CMP_W = (OFFSET_BITS > OFF_FIELD_W) ? OFFSET_BITS : OFF_FIELD_W;

   logic [OFFSET_BITS-1:0] read_ff, read_in;
   logic [RING_W-1:0]      ring_ff, ring_in;
   logic [LOOP_BITS-1:0]   loop_ff, loop_in;
   logic                   bad_ff, bad_in;
   logic [IDLE_W-1:0]      idle_ff, idle_in;
   logic [LEN_W-1:0]       accum_ff, accum_in;
   logic [CNT_W-1:0]       pkts_ff, pkts_in;
   logic [OFFSET_BITS-1:0] start_ff, start_in;
   logic                   over_ff, over_in;
   logic                   miss_ff, miss_in;
   logic                   out_valid_ff, out_valid_in;
   event_type              out_ff, out_in;

   logic                   fire;
   logic [OFFSET_BITS-1:0] wr_off;
   logic [LOOP_BITS-1:0]   next_loop;
   logic                   timeout;
   logic                   idle_poll;
   logic                   bov;
   logic                   lov;
   logic [OFFSET_BITS-1:0] new_off;
   logic [CMP_W-1:0]       new_off_x;
   logic [RING_W:0]        ring_nx;
   logic                   wrap;
   logic [LEN_W:0]         sum;
   logic [LEN_W-1:0]       len;
   logic                   emit;
   logic                   rec_len_zero;
   logic                   rec_end_missing;

   // Take a poll whenever the record register can hold a result
   assign fire     = head.valid && (!out_valid_ff || !rsp_stall);
   assign head_pop = fire;

   // Classify the poll against the current ring state
   assign wr_off    = OFFSET_BITS'(head.poll.write_offset);
   assign next_loop = loop_ff + 1'b1;
   assign timeout   = idle_ff > {1'b0, cfg.idle_limit};
   assign idle_poll = (read_ff == wr_off);
   assign bov       = ((head.poll.first_loop == next_loop) && (read_ff <= wr_off)) ||
                      (head.poll.first_loop > next_loop);
   assign lov       = (head.poll.entry_loop != loop_ff);
   assign new_off   = OFFSET_BITS'(CMP_W'(read_ff) + CMP_W'(head.poll.entry_length));
   assign new_off_x = CMP_W'(new_off);
   assign ring_nx   = {1'b0, ring_ff} + 1'b1;
   assign wrap      = (head.poll.entry_end &&
                       (new_off_x > CMP_W'(cfg.event_wrap_limit))) ||
                      (new_off_x > CMP_W'(cfg.packet_wrap_limit)) ||
                      (ring_nx >= {1'b0, cfg.ring_entries});
   assign sum       = {1'b0, accum_ff} + (LEN_W + 1)'(head.poll.entry_length);

   // Work out the next state and the record
   always_comb begin
      read_in         = read_ff;
      ring_in         = ring_ff;
      loop_in         = loop_ff;
      bad_in          = bad_ff;
      idle_in         = idle_ff;
      accum_in        = accum_ff;
      pkts_in         = pkts_ff;
      start_in        = start_ff;
      over_in         = over_ff;
      miss_in         = miss_ff;
      emit            = 1'b0;
      rec_len_zero    = 1'b0;
      rec_end_missing = 1'b1;
      len             = accum_ff;
      if (fire) begin
         if (timeout) begin
            emit = 1'b1;
         end else if (idle_poll) begin
            if (idle_ff != IDLE_MAX) begin
               idle_in = idle_ff + 1'b1;
            end
         end else if (bov || lov) begin
            // Resync on overwrite and discard the event
            read_in      = '0;
            ring_in      = '0;
            loop_in      = head.poll.first_loop;
            bad_in       = 1'b0;
            emit         = 1'b1;
            rec_len_zero = 1'b1;
         end else begin
            // Consume the packet
            idle_in = '0;
            if (pkts_ff == '0) begin
               start_in = read_ff;
            end
            if (wrap) begin
               read_in = '0;
               ring_in = '0;
               loop_in = next_loop;
            end else begin
               read_in = new_off;
               ring_in = ring_nx[RING_W-1:0];
            end
            if (pkts_ff != CNT_MAX) begin
               pkts_in = pkts_ff + 1'b1;
            end
            if (sum > {1'b0, cfg.max_event_bytes}) begin
               over_in = 1'b1;
            end
            len = sum[LEN_W] ? LEN_MAX : sum[LEN_W-1:0];
            if (bad_ff) begin
               len = '0;
            end
            if (head.poll.entry_missing) begin
               miss_in = 1'b1;
               bad_in  = 1'b1;
               len     = '0;
            end
            accum_in = len;
            if (head.poll.entry_end) begin
               bad_in          = 1'b0;
               emit            = 1'b1;
               rec_end_missing = 1'b0;
            end
         end
      end

      out_in.event_start      = (pkts_in != '0) ? OFF_FIELD_W'(start_in) : '0;
      out_in.event_length     = rec_len_zero ? '0 : accum_in;
      out_in.packet_count     = pkts_in;
      out_in.end_missing      = rec_end_missing;
      out_in.timed_out        = timeout;
      out_in.buffer_overwrite = !timeout && bov;
      out_in.loop_overwrite   = !timeout && !bov && lov;
      out_in.oversized        = over_in;
      out_in.packets_missing  = miss_in;

      // Clear accumulators once a record is formed
      if (emit) begin
         accum_in = '0;
         pkts_in  = '0;
         over_in  = 1'b0;
         miss_in  = 1'b0;
         idle_in  = '0;
      end

      out_valid_in = out_valid_ff && rsp_stall;
      if (emit) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         read_ff      <= '0;
         ring_ff      <= '0;
         loop_ff      <= '0;
         bad_ff       <= 1'b0;
         idle_ff      <= '0;
         accum_ff     <= '0;
         pkts_ff      <= '0;
         start_ff     <= '0;
         over_ff      <= 1'b0;
         miss_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         read_ff      <= read_in;
         ring_ff      <= ring_in;
         loop_ff      <= loop_in;
         bad_ff       <= bad_in;
         idle_ff      <= idle_in;
         accum_ff     <= accum_in;
         pkts_ff      <= pkts_in;
         start_ff     <= start_in;
         over_ff      <= over_in;
         miss_ff      <= miss_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Hold the record payload until it is taken
   always_ff @(posedge clock) begin
      if (emit) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_event = out_ff;

   // An overwrite resets the read pointer and ring index
   a_resync: assert property (@(posedge clock) disable iff (reset)
      fire && !timeout && !idle_poll && (bov || lov) |=> (read_ff == '0) && (ring_ff == '0))
      else $error("overwrite did not resync the ring pointers");

   // A discarded event reports no readable bytes
   a_discard_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_event.buffer_overwrite || rsp_event.loop_overwrite)
         |-> rsp_event.event_length == '0)
      else $error("overwrite record carries a length");

   // Accumulators are empty after every record
   a_clear: assert property (@(posedge clock) disable iff (reset)
      emit |=> (pkts_ff == '0) && (accum_ff == '0) && (idle_ff == '0))
      else $error("accumulators not cleared after record");

   // At most one cause flag per record
   a_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot0({rsp_event.timed_out, rsp_event.buffer_overwrite,
                              rsp_event.loop_overwrite}))
      else $error("record has more than one close cause");

endmodule
`default_nettype wire

// ===== rtl/packet_ring_event_assembler_core.sv =====
// Top level of the packet ring event assembler.
//
// Each item on the req_ channel is one poll of the packet ring: the producer's
// write offset, the descriptor at the current ring index and the loop count
// of ring entry zero. The rsp_ channel carries one event record whenever a
// poll closes an event (end packet, buffer or descriptor overwrite, idle
// timeout); most polls give no record. The csr_ channel writes the five
// limit registers by index and is always ready; write it only while idle.
// Polls enter a four-entry queue; the back end takes one poll per cycle while
// the record register can take a result, so the sustained rate is one poll per
// clock. An accepted poll is registered in the queue, and the record it closes
// in the output register. The ring pointer update in the back end sets that rate.
// A stalled record holds in the output register and also holds the back end,
// so no further poll is taken until the record leaves; the queue absorbs up
// to four polls and req_stall rises only when it is full.
// Synchronous reset empties the queue, clears all ring state and
// accumulators and loads the limit registers with their default values.
`default_nettype none
module packet_ring_event_assembler_core #(
   parameter int OFFSET_BITS = 24
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [prea_pkg::OFF_FIELD_W-1:0]  req_write_offset,
   input  wire logic                              req_entry_missing,
   input  wire logic                              req_entry_end,
   input  wire logic [prea_pkg::LOOP_BITS-1:0]    req_entry_loop,
   input  wire logic [prea_pkg::PKT_LEN_W-1:0]    req_entry_length,
   input  wire logic [prea_pkg::LOOP_BITS-1:0]    req_first_loop,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic [prea_pkg::OFF_FIELD_W-1:0]       rsp_event_start,
   output logic [prea_pkg::LEN_W-1:0]             rsp_event_length,
   output logic [prea_pkg::CNT_W-1:0]             rsp_packet_count,
   output logic                                   rsp_end_missing,
   output logic                                   rsp_timed_out,
   output logic                                   rsp_buffer_overwrite,
   output logic                                   rsp_loop_overwrite,
   output logic                                   rsp_oversized,
   output logic                                   rsp_packets_missing,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [prea_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [prea_pkg::CSR_DATA_W-1:0]   csr_data
);
   import prea_pkg::*;

   poll_type       req_poll;
   queue_head_type head;
   logic           head_pop;
   cfg_type        cfg;
   event_type      rsp_event;

   // Gather the poll fields
   assign req_poll.write_offset = req_write_offset;
   assign req_poll.entry_missing = req_entry_missing;
   assign req_poll.entry_end    = req_entry_end;
   assign req_poll.entry_loop   = req_entry_loop;
   assign req_poll.entry_length = req_entry_length;
   assign req_poll.first_loop   = req_first_loop;

   prea_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_poll  (req_poll),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .head_pop  (head_pop),
      .head      (head),
      .cfg       (cfg)
   );

   prea_back #(
      .OFFSET_BITS (OFFSET_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .head_pop  (head_pop),
      .cfg       (cfg),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_event (rsp_event)
   );

   // Spread the record onto its ports
   assign rsp_event_start      = rsp_event.event_start;
   assign rsp_event_length     = rsp_event.event_length;
   assign rsp_packet_count     = rsp_event.packet_count;
   assign rsp_end_missing      = rsp_event.end_missing;
   assign rsp_timed_out        = rsp_event.timed_out;
   assign rsp_buffer_overwrite = rsp_event.buffer_overwrite;
   assign rsp_loop_overwrite   = rsp_event.loop_overwrite;
   assign rsp_oversized        = rsp_event.oversized;
   assign rsp_packets_missing  = rsp_event.packets_missing;

endmodule
`default_nettype wire

// ===== tb/packet_ring_event_assembler_core_tb.sv =====
// Testbench for the packet ring event assembler: directed and random ring polls checked against a local model.
`timescale 1ns / 1ps
module packet_ring_event_assembler_core_tb;
   import prea_pkg::*;

   localparam int LONG_HOLD     = 200;
   localparam int SETTLE_CYCLES = 12;

   // Consumer-side ring state as the block keeps it
   typedef struct packed {
      logic [OFF_FIELD_W-1:0] rd_off;
      logic [RING_W-1:0]      ring_idx;
      logic [LOOP_BITS-1:0]   loop_cnt;
      logic                   bad_event;
      logic [IDLE_W-1:0]      idle_cnt;
      logic [LEN_W-1:0]       acc_len;
      logic [CNT_W-1:0]       acc_pkts;
      logic [OFF_FIELD_W-1:0] start_off;
      logic                   over_flag;
      logic                   miss_flag;
   } ring_state_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_valid = 1'b0;
   logic                  req_stall;
   poll_type              cur_poll = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [OFF_FIELD_W-1:0] rsp_event_start;
   logic [LEN_W-1:0]      rsp_event_length;
   logic [CNT_W-1:0]      rsp_packet_count;
   logic                  rsp_end_missing;
   logic                  rsp_timed_out;
   logic                  rsp_buffer_overwrite;
   logic                  rsp_loop_overwrite;
   logic                  rsp_oversized;
   logic                  rsp_packets_missing;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_PACKET_WRAP;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   // Model state, register copy and scoreboard
   ring_state_type ring_st = '0;
   ring_state_type gen_st = '0;
   cfg_type     ring_cfg = '{packet_wrap_limit: RST_PACKET_WRAP,
                             event_wrap_limit: RST_EVENT_WRAP,
                             ring_entries: RST_RING_ENTRIES,
                             max_event_bytes: RST_MAX_BYTES,
                             idle_limit: RST_IDLE_LIMIT};
   poll_type    poll_queue[$];
   event_type   awaited_records[$];
   int          polls_issued = 0;
   int          polls_taken = 0;
   int          mismatches = 0;
   logic        req_took = 1'b0;
   int          send_idle_pct = 0;
   int          stall_pct = 0;
   int          holds_asked = 0;
   int          holds_done = 0;
   int          hold_left = 0;

   packet_ring_event_assembler_core dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_write_offset(cur_poll.write_offset),
      .req_entry_missing(cur_poll.entry_missing),
      .req_entry_end(cur_poll.entry_end),
      .req_entry_loop(cur_poll.entry_loop),
      .req_entry_length(cur_poll.entry_length),
      .req_first_loop(cur_poll.first_loop),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_event_start(rsp_event_start),
      .rsp_event_length(rsp_event_length),
      .rsp_packet_count(rsp_packet_count),
      .rsp_end_missing(rsp_end_missing),
      .rsp_timed_out(rsp_timed_out),
      .rsp_buffer_overwrite(rsp_buffer_overwrite),
      .rsp_loop_overwrite(rsp_loop_overwrite),
      .rsp_oversized(rsp_oversized),
      .rsp_packets_missing(rsp_packets_missing),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #10 clock = ~clock;

   // Build the event record and clear the accumulators
   task automatic close_event(inout ring_state_type s, input logic [LEN_W-1:0] len,
                              input logic em, input logic tmo, input logic bov,
                              input logic lov, output event_type r);
      r.event_start      = (s.acc_pkts != 0) ? s.start_off : '0;
      r.event_length     = len;
      r.packet_count     = s.acc_pkts;
      r.end_missing      = em;
      r.timed_out        = tmo;
      r.buffer_overwrite = bov;
      r.loop_overwrite   = lov;
      r.oversized        = s.over_flag;
      r.packets_missing  = s.miss_flag;
      s.acc_len   = '0;
      s.acc_pkts  = '0;
      s.over_flag = 1'b0;
      s.miss_flag = 1'b0;
      s.idle_cnt  = '0;
   endtask

   // Apply one poll to the ring state; report whether it closes an event
   task automatic advance_ring(inout ring_state_type s, input poll_type p, input cfg_type c,
                               output bit closes, output event_type r);
      logic [LOOP_BITS-1:0] next_loop;
      int unsigned sum, len, idx;
      closes = 1'b0;
      r = '0;
      next_loop = s.loop_cnt + 1'b1;
      if (s.idle_cnt > {1'b0, c.idle_limit}) begin
         close_event(s, s.acc_len, 1'b1, 1'b1, 1'b0, 1'b0, r);
         closes = 1'b1;
      end else if (s.rd_off == p.write_offset) begin
         if (s.idle_cnt != IDLE_MAX)
            s.idle_cnt = s.idle_cnt + 1'b1;
      end else begin
         s.idle_cnt = '0;
         if ((p.first_loop == next_loop && s.rd_off <= p.write_offset) ||
             p.first_loop > next_loop || p.entry_loop != s.loop_cnt) begin
            // Resync on buffer overwrite first, then on descriptor overwrite
            closes = 1'b1;
            r.buffer_overwrite = (p.first_loop == next_loop && s.rd_off <= p.write_offset) ||
                                 p.first_loop > next_loop;
            s.rd_off    = '0;
            s.ring_idx  = '0;
            s.loop_cnt  = p.first_loop;
            s.bad_event = 1'b0;
            close_event(s, '0, 1'b1, 1'b0, r.buffer_overwrite, !r.buffer_overwrite, r);
         end else begin
            // Consume the packet and advance the read side
            if (s.acc_pkts == 0)
               s.start_off = s.rd_off;
            sum = s.acc_len + p.entry_length;
            s.rd_off = s.rd_off + p.entry_length;
            idx = s.ring_idx + 1;
            if ((p.entry_end && s.rd_off > c.event_wrap_limit) ||
                s.rd_off > c.packet_wrap_limit || idx >= c.ring_entries) begin
               idx = 0;
               s.loop_cnt = next_loop;
               s.rd_off = '0;
            end
            s.ring_idx = idx[RING_W-1:0];
            if (s.acc_pkts != CNT_MAX)
               s.acc_pkts = s.acc_pkts + 1'b1;
            if (sum > c.max_event_bytes)
               s.over_flag = 1'b1;
            len = (sum > LEN_MAX) ? LEN_MAX : sum;
            if (s.bad_event)
               len = 0;
            if (p.entry_missing) begin
               s.miss_flag = 1'b1;
               s.bad_event = 1'b1;
               len = 0;
            end
            s.acc_len = len[LEN_W-1:0];
            if (p.entry_end) begin
               s.bad_event = 1'b0;
               close_event(s, s.acc_len, 1'b0, 1'b0, 1'b0, 1'b0, r);
               closes = 1'b1;
            end
         end
      end
   endtask

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endfunction

   // Sample both handshakes; predict on each accepted poll, check each record
   always @(posedge clock) begin : watch
      event_type want;
      bit closes;
      req_took <= !reset && req_valid && !req_stall;
      if (!reset && req_valid && !req_stall) begin
         polls_taken++;
         advance_ring(ring_st, cur_poll, ring_cfg, closes, want);
         if (closes)
            awaited_records.push_back(want);
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_records.size() == 0) begin
            $error("event record arrived with none expected");
            mismatches++;
         end else begin
            want = awaited_records.pop_front();
            check_field("event_start", want.event_start, rsp_event_start);
            check_field("event_length", want.event_length, rsp_event_length);
            check_field("packet_count", want.packet_count, rsp_packet_count);
            check_field("end_missing", want.end_missing, rsp_end_missing);
            check_field("timed_out", want.timed_out, rsp_timed_out);
            check_field("buffer_overwrite", want.buffer_overwrite, rsp_buffer_overwrite);
            check_field("loop_overwrite", want.loop_overwrite, rsp_loop_overwrite);
            check_field("oversized", want.oversized, rsp_oversized);
            check_field("packets_missing", want.packets_missing, rsp_packets_missing);
         end
      end
   end

   // Offer the next poll; hold a poll until it is taken
   always @(negedge clock) begin : drive_polls
      logic offer;
      poll_type nxt;
      offer = req_valid;
      nxt = cur_poll;
      if (!req_valid || req_took) begin
         offer = 1'b0;
         if (!reset && poll_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            nxt = poll_queue.pop_front();
            offer = 1'b1;
         end
      end
      req_valid <= offer;
      cur_poll <= nxt;
   end

   // Stall records at random, or for a long stretch on request
   always @(negedge clock) begin : drive_stall
      logic stall;
      if (holds_done != holds_asked) begin
         holds_done++;
         hold_left = LONG_HOLD;
      end
      if (hold_left != 0) begin
         stall = 1'b1;
         hold_left--;
      end else begin
         stall = ($urandom_range(0, 99) < stall_pct);
      end
      rsp_stall <= stall;
   end

   task automatic put_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (csr_ready !== 1'b1);
   endtask

   task automatic load_config(input cfg_type c);
      put_reg(CSR_PACKET_WRAP, c.packet_wrap_limit);
      put_reg(CSR_EVENT_WRAP, c.event_wrap_limit);
      put_reg(CSR_RING_ENTRIES, CSR_DATA_W'(c.ring_entries));
      put_reg(CSR_MAX_BYTES, CSR_DATA_W'(c.max_event_bytes));
      put_reg(CSR_IDLE_LIMIT, CSR_DATA_W'(c.idle_limit));
      ring_cfg = c;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic cfg_type mk_cfg(int unsigned pw, int unsigned ew, int unsigned re,
                                      int unsigned mb, int unsigned il);
      cfg_type c;
      c.packet_wrap_limit = OFF_FIELD_W'(pw);
      c.event_wrap_limit  = OFF_FIELD_W'(ew);
      c.ring_entries      = RING_W'(re);
      c.max_event_bytes   = LEN_W'(mb);
      c.idle_limit        = LIMIT_W'(il);
      return c;
   endfunction

   // Queue a poll and track where the ring will stand after it
   task automatic queue_poll(input poll_type p);
      bit closes;
      event_type unused;
      poll_queue.push_back(p);
      polls_issued++;
      advance_ring(gen_st, p, ring_cfg, closes, unused);
   endtask

   // Well-formed poll: new data, descriptor in step with the ring
   task automatic shape_poll(input int unsigned len, input logic last, input logic miss,
                             output poll_type p);
      p.write_offset  = gen_st.rd_off + 24'd5000;
      p.entry_missing = miss;
      p.entry_end     = last;
      p.entry_loop    = gen_st.loop_cnt;
      p.entry_length  = PKT_LEN_W'(len);
      p.first_loop    = gen_st.loop_cnt;
   endtask

   // Random poll, mostly well formed, with idle, overwrite and noise mixed in
   task automatic make_poll(input int end_pct, input int miss_pct, input bit big,
                            input bit clean, output poll_type p);
      int kind;
      logic [LOOP_BITS-1:0] next_loop;
      next_loop = gen_st.loop_cnt + 1'b1;
      kind = clean ? 99 : $urandom_range(0, 99);
      p.entry_loop    = gen_st.loop_cnt;
      p.first_loop    = gen_st.loop_cnt;
      p.write_offset  = gen_st.rd_off + 24'($urandom_range(1, 70000));
      p.entry_end     = ($urandom_range(0, 99) < end_pct);
      p.entry_missing = ($urandom_range(0, 99) < miss_pct);
      if (big)
         p.entry_length = PKT_LEN_W'($urandom_range(30000, 65535));
      else if ($urandom_range(0, 3) == 0)
         p.entry_length = PKT_LEN_W'($urandom);
      else
         p.entry_length = PKT_LEN_W'($urandom_range(0, 1500));
      if (kind < 12) begin
         p.write_offset = gen_st.rd_off;
      end else if (kind < 20) begin
         if (next_loop != '1 && $urandom_range(0, 1) == 1)
            p.first_loop = LOOP_BITS'($urandom_range(next_loop + 1, 16383));
         else
            p.first_loop = next_loop;
      end else if (kind < 27) begin
         p.entry_loop = gen_st.loop_cnt ^ LOOP_BITS'($urandom_range(1, 16383));
      end else if (kind < 32) begin
         p.write_offset  = OFF_FIELD_W'($urandom);
         p.entry_missing = ($urandom_range(0, 1) == 1);
         p.entry_end     = ($urandom_range(0, 1) == 1);
         p.entry_loop    = LOOP_BITS'($urandom);
         p.entry_length  = PKT_LEN_W'($urandom);
         p.first_loop    = LOOP_BITS'($urandom);
      end else if (!clean && gen_st.rd_off != 0 && $urandom_range(0, 4) == 0) begin
         // Producer already looped but still sits behind the read offset
         p.first_loop = next_loop;
         p.write_offset = OFF_FIELD_W'($urandom_range(0, gen_st.rd_off - 1));
      end
   endtask

   // Wait until every poll is taken and every record has come, then settle
   task automatic drain();
      do @(negedge clock); while (polls_taken != polls_issued || awaited_records.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic run_phase(input cfg_type c, input int snd_idle, input int rcv_stall,
                            input int count, input int end_pct, input int miss_pct,
                            input bit big, input bit clean, input bit hold, input bit seal);
      poll_type p;
      load_config(c);
      send_idle_pct = snd_idle;
      stall_pct = rcv_stall;
      gen_st = ring_st;
      if (hold)
         holds_asked++;
      repeat (count) begin
         make_poll(end_pct, miss_pct, big, clean, p);
         queue_poll(p);
      end
      if (seal) begin
         make_poll(100, 0, big, 1'b1, p);
         queue_poll(p);
      end
      drain();
   endtask

   initial begin : stimulus
      poll_type p;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: idle, wraps, oversize, missing packets, timeout, overwrites
      load_config(mk_cfg(3000, 2000, 4, 500, 1));
      gen_st = ring_st;
      p = '0;
      queue_poll(p);
      shape_poll(100, 0, 0, p);    queue_poll(p);
      shape_poll(200, 1, 0, p);    queue_poll(p);
      shape_poll(400, 0, 1, p);    queue_poll(p);
      shape_poll(100, 1, 0, p);    queue_poll(p);
      shape_poll(2500, 1, 0, p);   queue_poll(p);
      shape_poll(3500, 0, 0, p);   queue_poll(p);
      shape_poll(65535, 0, 0, p);  queue_poll(p);
      shape_poll(0, 1, 0, p);      queue_poll(p);
      p.write_offset = gen_st.rd_off;
      queue_poll(p);
      queue_poll(p);
      shape_poll(77, 1, 0, p);     queue_poll(p);
      shape_poll(10, 0, 0, p);
      p.first_loop = '1;
      queue_poll(p);
      shape_poll(10, 0, 0, p);
      p.first_loop = gen_st.loop_cnt + 1'b1;
      queue_poll(p);
      shape_poll(50, 0, 0, p);     queue_poll(p);
      shape_poll(10, 0, 0, p);
      p.first_loop = gen_st.loop_cnt + 1'b1;
      p.write_offset = gen_st.rd_off + 24'd10;
      queue_poll(p);
      shape_poll(60, 0, 0, p);     queue_poll(p);
      shape_poll(30, 1, 0, p);
      p.first_loop = gen_st.loop_cnt + 1'b1;
      p.write_offset = 24'd10;
      queue_poll(p);
      shape_poll(40, 0, 0, p);
      p.entry_loop = gen_st.loop_cnt + 2'd3;
      queue_poll(p);
      p = '1;
      queue_poll(p);
      p = '0;
      queue_poll(p);
      drain();

      // Random phases over several register settings and idle patterns
      run_phase(mk_cfg(5000, 3000, 8, 3000, 3), 0, 0, 300, 20, 8, 0, 0, 0, 0);
      run_phase(mk_cfg(16777215, 16777215, 65535, 1048575, 65535), 71, 0, 300, 20, 8,
                0, 0, 0, 0);
      run_phase(mk_cfg(0, 0, 1, 0, 0), 0, 71, 300, 20, 8, 0, 0, 0, 0);
      run_phase(mk_cfg(20000, 10000, 0, 50000, 6), 19, 19, 300, 20, 8, 0, 0, 0, 0);
      run_phase(mk_cfg(8000, 6000, 32, 4000, 4), 0, 0, 150, 70, 8, 0, 0, 1, 0);
      run_phase(mk_cfg(16777215, 15000000, 65535, 1048575, 65535), 19, 19, 300, 0, 0,
                1, 1, 0, 1);

      if (mismatches == 0)
         $display("packet_ring_event_assembler_core_tb passed");
      else
         $display("packet_ring_event_assembler_core_tb failed");
      $finish;
   end

   // Guard against a hang
   initial begin : watchdog
      #4000000;
      $display("packet_ring_event_assembler_core_tb failed");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/prea_pkg.sv
rtl/prea_front.sv
rtl/prea_back.sv
rtl/packet_ring_event_assembler_core.sv
tb/packet_ring_event_assembler_core_tb.sv
